FILE: hw/rtl/direct_dft_engine_core_macros.svh
// Assertion macros shared by the direct DFT engine modules.
`ifndef DIRECT_DFT_ENGINE_CORE_MACROS_SVH
`define DIRECT_DFT_ENGINE_CORE_MACROS_SVH

// Clocked check, disabled while in reset.
`define DDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds across reset.
`define DDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hw/rtl/dde_pkg.sv
// Shared types and constants of the direct DFT engine.
package dde_pkg;

  localparam int unsigned IDX_W = 6;
  localparam int unsigned BIN_W = 23;
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_HOLD,
    ST_RUN
  } ctrl_state_e;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] n;
    logic [IDX_W-1:0] m;
    logic [IDX_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } status_t;

endpackage

FILE: hw/rtl/dde_ctrl.sv
// Sequencer: loads a frame, then walks bins and terms of the transform.
`include "direct_dft_engine_core_macros.svh"

module dde_ctrl #(
  parameter int POINTS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output dde_pkg::cmd_t   cmd_o,
  input  dde_pkg::status_t status_i
);
  import dde_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);
  localparam logic [IDX_W:0]   PTS_EXT  = (IDX_W + 1)'(POINTS);

  ctrl_state_e      state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic [IDX_W-1:0] m_q, m_d;
  logic [IDX_W:0]   m_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      k_q     <= '0;
      m_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      m_q     <= m_d;
    end
  end

  assign m_sum = {1'b0, m_q} + {1'b0, k_q};

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    m_d        = m_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.n    = cnt_q;
    cmd_o.m    = m_q;
    cmd_o.k    = k_q;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.wr_en = 1'b1;
          if (cnt_q == LAST_IDX) begin
            cnt_d   = '0;
            k_d     = '0;
            state_d = ST_HOLD;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_HOLD: begin
        if (!status_i.busy) begin
          cnt_d   = '0;
          m_d     = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.first = (cnt_q == '0);
        cmd_o.last  = (cnt_q == LAST_IDX);
        m_d = (m_sum >= PTS_EXT) ? IDX_W'(m_sum - PTS_EXT) : m_sum[IDX_W-1:0];
        if (cnt_q == LAST_IDX) begin
          cnt_d = '0;
          if (k_q == LAST_IDX) begin
            k_d     = '0;
            state_d = ST_LOAD;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_HOLD;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  `DDE_ASSERT(a_hold_waits, (state_q == ST_HOLD && status_i.busy) |=> (state_q == ST_HOLD), "bin started while the MAC pipeline was busy")
  `DDE_ASSERT(a_m_range, (state_q == ST_RUN) |-> (m_q <= LAST_IDX), "twiddle index out of range")
  `DDE_ASSERT_ALWAYS(a_rd_wr_excl, !(cmd_o.wr_en && cmd_o.rd_en), "sample store read and write together")

endmodule

FILE: hw/rtl/dde_datapath.sv
// Sample store, twiddle table, complex MAC pipeline and output register.
`include "direct_dft_engine_core_macros.svh"

module dde_datapath #(
  parameter int POINTS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dde_pkg::cmd_t               cmd_i,
  output dde_pkg::status_t            status_o,
  input  logic signed [15:0]          sample_re_i,
  input  logic signed [15:0]          sample_im_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [dde_pkg::BIN_W-1:0] bin_re_o,
  output logic signed [dde_pkg::BIN_W-1:0] bin_im_o,
  output logic [dde_pkg::IDX_W-1:0]   bin_index_o,
  output logic                        last_bin_o
);
  import dde_pkg::*;

  localparam int unsigned IW    = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int unsigned ACC_W = (34 + IW > 15 + BIN_W) ? 34 + IW : 15 + BIN_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

  function automatic longint q30_mul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint clamp0(longint v);
    return (v < 0) ? 64'sd0 : v;
  endfunction

  function automatic logic signed [15:0] to_q15(longint v);
    longint rr;
    rr = (v + 64'sd16384) >>> 15;
    if (rr > 64'sd32767) rr = 64'sd32767;
    return 16'(rr);
  endfunction

  // Q1.15 cos in the upper half, sin in the lower half.
  function automatic logic [31:0] tw_entry(int unsigned m);
    longint q, r, x, x2, ts, tc;
    logic signed [15:0] sv, cv, co, si;
    q  = longint'((4 * m) / POINTS);
    r  = longint'(4 * m) - q * longint'(POINTS);
    x  = (r * HALF_PI_Q30) / POINTS;
    x2 = q30_mul(x, x);
    ts = Q30_ONE;
    ts = clamp0(Q30_ONE - q30_mul(x2, ts) / 156);
    ts = clamp0(Q30_ONE - q30_mul(x2, ts) / 110);
    ts = clamp0(Q30_ONE - q30_mul(x2, ts) / 72);
    ts = clamp0(Q30_ONE - q30_mul(x2, ts) / 42);
    ts = clamp0(Q30_ONE - q30_mul(x2, ts) / 20);
    ts = clamp0(Q30_ONE - q30_mul(x2, ts) / 6);
    tc = Q30_ONE;
    tc = clamp0(Q30_ONE - q30_mul(x2, tc) / 182);
    tc = clamp0(Q30_ONE - q30_mul(x2, tc) / 132);
    tc = clamp0(Q30_ONE - q30_mul(x2, tc) / 90);
    tc = clamp0(Q30_ONE - q30_mul(x2, tc) / 56);
    tc = clamp0(Q30_ONE - q30_mul(x2, tc) / 30);
    tc = clamp0(Q30_ONE - q30_mul(x2, tc) / 12);
    tc = clamp0(Q30_ONE - q30_mul(x2, tc) / 2);
    sv = to_q15(q30_mul(x, ts));
    cv = to_q15(tc);
    case (q[1:0])
      2'd0:    begin co = cv;  si = sv;  end
      2'd1:    begin co = -sv; si = cv;  end
      2'd2:    begin co = -cv; si = -sv; end
      default: begin co = sv;  si = -cv; end
    endcase
    return {co, si};
  endfunction

  logic signed [15:0] cos_tab [POINTS];
  logic signed [15:0] sin_tab [POINTS];

  for (genvar g = 0; g < POINTS; g++) begin : g_tw
    localparam logic [31:0] ENTRY = tw_entry(g);
    assign cos_tab[g] = ENTRY[31:16];
    assign sin_tab[g] = ENTRY[15:0];
  end

  logic signed [15:0] mem_re [POINTS];
  logic signed [15:0] mem_im [POINTS];

  // stage 1: store and table reads
  logic signed [15:0] xr_q, xi_q, c_q, s_q;
  logic               s1_v_q, s1_first_q, s1_last_q;
  logic [IDX_W-1:0]   s1_k_q;
  // stage 2: products
  logic signed [31:0] p_rc_q, p_is_q, p_ic_q, p_rs_q;
  logic               s2_v_q, s2_first_q, s2_last_q;
  logic [IDX_W-1:0]   s2_k_q;
  // stage 3: accumulate
  logic signed [32:0]      term_re, term_im;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q, sum_re, sum_im;
  logic signed [BIN_W-1:0] res_re_q, res_im_q;
  logic [IDX_W-1:0]        res_k_q;
  logic                    res_valid_q;
  // output register
  logic                    out_valid_q, out_load;
  logic signed [BIN_W-1:0] out_re_q, out_im_q;
  logic [IDX_W-1:0]        out_k_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_re[cmd_i.n[IW-1:0]] <= sample_re_i;
      mem_im[cmd_i.n[IW-1:0]] <= sample_im_i;
    end
    if (cmd_i.rd_en) begin
      xr_q <= mem_re[cmd_i.n[IW-1:0]];
      xi_q <= mem_im[cmd_i.n[IW-1:0]];
      c_q  <= cos_tab[cmd_i.m[IW-1:0]];
      s_q  <= sin_tab[cmd_i.m[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.rd_en;
      s2_v_q <= s1_v_q;
      if (s2_v_q && s2_last_q) begin
        res_valid_q <= 1'b1;
      end else if (out_load) begin
        res_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= cmd_i.first;
    s1_last_q  <= cmd_i.last;
    s1_k_q     <= cmd_i.k;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_k_q     <= s1_k_q;
    p_rc_q     <= xr_q * c_q;
    p_is_q     <= xi_q * s_q;
    p_ic_q     <= xi_q * c_q;
    p_rs_q     <= xr_q * s_q;
    if (s2_v_q) begin
      acc_re_q <= sum_re;
      acc_im_q <= sum_im;
    end
    if (s2_v_q && s2_last_q) begin
      res_re_q <= sum_re[15 +: BIN_W];
      res_im_q <= sum_im[15 +: BIN_W];
      res_k_q  <= s2_k_q;
    end
    if (out_load) begin
      out_re_q <= res_re_q;
      out_im_q <= res_im_q;
      out_k_q  <= res_k_q;
    end
  end

  assign term_re = 33'(p_rc_q) + 33'(p_is_q);
  assign term_im = 33'(p_ic_q) - 33'(p_rs_q);
  assign sum_re  = ACC_W'(term_re) + (s2_first_q ? ACC_W'(0) : acc_re_q);
  assign sum_im  = ACC_W'(term_im) + (s2_first_q ? ACC_W'(0) : acc_im_q);

  assign out_load      = res_valid_q && (!out_valid_q || out_ready_i);
  assign status_o.busy = s1_v_q || s2_v_q || res_valid_q;

  assign out_valid_o = out_valid_q;
  assign bin_re_o    = out_re_q;
  assign bin_im_o    = out_im_q;
  assign bin_index_o = out_k_q;
  assign last_bin_o  = (out_k_q == LAST_IDX);

  `DDE_ASSERT(a_res_free, (s2_v_q && s2_last_q) |-> !res_valid_q, "bin finished while previous result still held")
  `DDE_ASSERT(a_out_from_res, $rose(out_valid_q) |-> $past(res_valid_q), "output beat without a finished bin")
  `DDE_ASSERT(a_first_starts, (s1_v_q && !s1_first_q) |-> s2_v_q, "accumulation continued without a preceding term")

endmodule

FILE: hw/rtl/direct_dft_engine_core.sv
// Top level of the direct DFT engine.
// Takes POINTS complex samples, one beat per cycle, then computes all POINTS
// bins by direct summation with a single complex multiply-accumulate unit fed
// from the sample store and a Q1.15 twiddle table; no input beat is taken
// while a transform runs. Each bin feeds POINTS terms through the three-stage
// MAC pipeline, which drains and hands its result to the output register
// before the next bin starts. Results leave in bin order with tlast on bin
// POINTS-1; the next frame may load while the last bins still wait to be
// taken.
module direct_dft_engine_core #(
  parameter int POINTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] sample_re, [31:16] sample_im
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [22:0] bin_re, [45:23] bin_im, [51:46] bin_index
  output logic        m_axis_tlast
);
  import dde_pkg::*;

  cmd_t                    cmd;
  status_t                 status;
  logic signed [BIN_W-1:0] bin_re, bin_im;
  logic [IDX_W-1:0]        bin_index;

  dde_ctrl #(
    .POINTS(POINTS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  dde_datapath #(
    .POINTS(POINTS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .sample_re_i(s_axis_tdata[15:0]),
    .sample_im_i(s_axis_tdata[31:16]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .bin_re_o   (bin_re),
    .bin_im_o   (bin_im),
    .bin_index_o(bin_index),
    .last_bin_o (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, bin_index, bin_im, bin_re};

endmodule

FILE: tb/dft_bin_checker.sv
// Scoreboard for the direct DFT engine: mirrors the sample store, predicts each bin, compares.
module dft_bin_checker #(
  parameter int POINTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] sample_re, [31:16] sample_im
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,   // [22:0] bin_re, [45:23] bin_im, [51:46] bin_index
  input  logic        m_axis_tlast,
  output int          errors_o,
  output int          pending_o
);
  import dde_pkg::*;

  localparam longint QONE    = 64'sd1 << 30;
  localparam longint HALF_PI = 64'sd1686629713;

  typedef struct packed {
    logic signed [BIN_W-1:0] re;
    logic signed [BIN_W-1:0] im;
    logic [IDX_W-1:0]        idx;
    logic                    last;
  } bin_t;

  logic signed [15:0] samples_re [POINTS];
  logic signed [15:0] samples_im [POINTS];
  longint             cos_rom [POINTS];
  longint             sin_rom [POINTS];
  int                 fill_cnt;
  bin_t               bins_due [$];
  bin_t               want;
  bin_t               got;

  function automatic longint taylor_step(longint x2, longint t, longint d);
    longint v;
    v = QONE - ((x2 * t) >>> 30) / d;
    return (v < 0) ? 0 : v;
  endfunction

  function automatic longint round_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    return (r > 32767) ? 32767 : r;
  endfunction

  // Q1.15 cos/sin table, fixed-point Taylor series per quadrant
  function automatic void build_twiddle_rom();
    int     m;
    int     j;
    int     q;
    longint r;
    longint x;
    longint x2;
    longint ts;
    longint tc;
    longint sv;
    longint cv;
    for (m = 0; m < POINTS; m++) begin
      q  = (4 * m) / POINTS;
      r  = longint'(4 * m - q * POINTS);
      x  = (r * HALF_PI) / POINTS;
      x2 = (x * x) >>> 30;
      ts = QONE;
      tc = QONE;
      for (j = 6; j >= 1; j--) ts = taylor_step(x2, ts, longint'((2 * j) * (2 * j + 1)));
      for (j = 7; j >= 1; j--) tc = taylor_step(x2, tc, longint'((2 * j - 1) * (2 * j)));
      sv = round_q15((x * ts) >>> 30);
      cv = round_q15(tc);
      case (q % 4)
        0: begin
          cos_rom[m] = cv;
          sin_rom[m] = sv;
        end
        1: begin
          cos_rom[m] = -sv;
          sin_rom[m] = cv;
        end
        2: begin
          cos_rom[m] = -cv;
          sin_rom[m] = -sv;
        end
        default: begin
          cos_rom[m] = sv;
          sin_rom[m] = -cv;
        end
      endcase
    end
  endfunction

  function automatic void queue_frame_bins();
    int     k;
    int     n;
    int     m;
    longint acc_re;
    longint acc_im;
    longint xr;
    longint xi;
    bin_t   b;
    for (k = 0; k < POINTS; k++) begin
      acc_re = 0;
      acc_im = 0;
      for (n = 0; n < POINTS; n++) begin
        m = (k * n) % POINTS;
        xr = longint'(samples_re[n]);
        xi = longint'(samples_im[n]);
        acc_re += xr * cos_rom[m] + xi * sin_rom[m];
        acc_im += xi * cos_rom[m] - xr * sin_rom[m];
      end
      b.re   = BIN_W'(acc_re >>> 15);
      b.im   = BIN_W'(acc_im >>> 15);
      b.idx  = IDX_W'(k);
      b.last = (k == POINTS - 1);
      bins_due.push_back(b);
    end
  endfunction

  initial begin
    build_twiddle_rom();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.re   = m_axis_tdata[22:0];
        got.im   = m_axis_tdata[45:23];
        got.idx  = m_axis_tdata[51:46];
        got.last = m_axis_tlast;
        if (bins_due.size() == 0) begin
          $error("result beat with no bin due: bin_index %0d", got.idx);
          errors_o++;
        end else begin
          want = bins_due.pop_front();
          if (got.re !== want.re) begin
            $error("bin_re: expected %0d, got %0d", want.re, got.re);
            errors_o++;
          end
          if (got.im !== want.im) begin
            $error("bin_im: expected %0d, got %0d", want.im, got.im);
            errors_o++;
          end
          if (got.idx !== want.idx) begin
            $error("bin_index: expected %0d, got %0d", want.idx, got.idx);
            errors_o++;
          end
          if (got.last !== want.last) begin
            $error("last_bin: expected %0d, got %0d", want.last, got.last);
            errors_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        samples_re[fill_cnt] = s_axis_tdata[15:0];
        samples_im[fill_cnt] = s_axis_tdata[31:16];
        if (fill_cnt == POINTS - 1) begin
          fill_cnt = 0;
          queue_frame_bins();
        end else begin
          fill_cnt++;
        end
      end
      pending_o = bins_due.size();
    end
  end

endmodule

FILE: tb/direct_dft_engine_core_test.sv
// Testbench top for the direct DFT engine: clock, reset, sample frames, receiver stalls, verdict.
module direct_dft_engine_core_test;

  localparam int POINTS    = 64;
  localparam int FRAMES    = 7;
  localparam int LONG_HOLD = 3000;
  localparam int TAIL      = 400;

  typedef enum int {FR_CORNERS, FR_EXTREME, FR_SPIKE, FR_FLAT, FR_SMALL, FR_NOISE} frame_kind_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          errors;
  int          pending;
  int          bins_taken = 0;

  direct_dft_engine_core #(.POINTS(POINTS)) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  dft_bin_checker #(.POINTS(POINTS)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) bins_taken <= bins_taken + 1;
  end

  // {sample_im, sample_re}
  function automatic logic [31:0] frame_sample(frame_kind_e kind, int idx, logic [31:0] level,
                                               int spike_at);
    logic [31:0] r;
    r = $urandom;
    case (kind)
      FR_CORNERS: begin
        case (idx)
          0: return {16'h7FFF, 16'h7FFF};
          1: return {16'h8000, 16'h8000};
          2: return {16'h8000, 16'h7FFF};
          3: return {16'h7FFF, 16'h8000};
          4: return 32'h0;
          5: return {16'hFFFF, 16'h0001};
          6: return {16'h0001, 16'hFFFF};
          7: return {16'hAAAA, 16'h5555};
          8: return {16'h5555, 16'hAAAA};
          9: return {16'hFFFF, 16'hFFFF};
          default: return r;
        endcase
      end
      FR_EXTREME: return {r[1] ? 16'h7FFF : 16'h8000, r[0] ? 16'h7FFF : 16'h8000};
      FR_SPIKE:   return (idx == spike_at) ? level : 32'h0;
      FR_FLAT:    return level;
      FR_SMALL:   return {{13{r[18]}}, r[18:16], {13{r[2]}}, r[2:0]};
      default:    return r;
    endcase
  endfunction

  // sender: whole frames, bursts with random gaps
  initial begin
    frame_kind_e kind;
    logic [31:0] level;
    int          spike_at;
    int          burst_left;
    int          gap;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    burst_left    = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int f = 0; f < FRAMES; f++) begin
      case (f)
        0: kind = FR_CORNERS;
        1: kind = FR_EXTREME;
        2: kind = FR_SPIKE;
        default: begin
          case ($urandom_range(0, 5))
            0: kind = FR_FLAT;
            1: kind = FR_SMALL;
            2: kind = FR_SPIKE;
            3: kind = FR_EXTREME;
            default: kind = FR_NOISE;
          endcase
        end
      endcase
      level    = $urandom;
      spike_at = $urandom_range(0, POINTS - 1);
      for (int i = 0; i < POINTS; i++) begin
        if (burst_left == 0) begin
          gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          burst_left = $urandom_range(1, 40);
          if (gap > 0) begin
            @(negedge clk_i);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk_i);
          end
        end
        @(negedge clk_i);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= frame_sample(kind, i, level, spike_at);
        do @(posedge clk_i); while (!s_axis_tready);
        burst_left--;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("direct_dft_engine_core_test OK");
    end else begin
      $display("direct_dft_engine_core_test NOT OK");
    end
    $finish;
  end

  // receiver: changing stall patterns, one long hold-off near the end of the second frame
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       cyc;
    int       hold_left;
    bit       held;
    m_axis_tready = 1'b0;
    mode          = RX_OPEN;
    mode_left     = 0;
    cyc           = 0;
    hold_left     = 0;
    held          = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (!held && bins_taken >= 2 * POINTS - 3) begin
        held      = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= (cyc % 5 < 3);
        endcase
      end
    end
  end

  initial begin
    #1000000;
    $display("direct_dft_engine_core_test NOT OK");
    $finish;
  end

endmodule
